/* hw/rtl/gregorian_date_add_compare_assert.svh */
// ----------------------------------------------------------------------------
// gregorian date add/compare assertion macros
// shared concurrent assertion forms for the port checker
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_COMPARE_ASSERT_SVH
`define GREGORIAN_DATE_ADD_COMPARE_ASSERT_SVH

// same-cycle implication, disabled while reset is asserted
`define GDAC_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("gdac assertion failed");

// next-cycle implication, disabled while reset is asserted
`define GDAC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("gdac assertion failed");

`endif

/* hw/rtl/gdac_pkg.sv */
// ----------------------------------------------------------------------------
// gdac_pkg
// types, widths and calendar helpers for the gregorian date add/compare block
// ----------------------------------------------------------------------------
package gdac_pkg;

  localparam int unsigned GDAC_YEAR_W    = 14;
  localparam int unsigned GDAC_MONTH_W   = 4;
  localparam int unsigned GDAC_DAY_W     = 5;
  localparam int unsigned GDAC_OFFSET_W  = 16;
  // year while walking: a 14-bit year plus carried years
  localparam int unsigned GDAC_WYEAR_W   = 15;
  // day accumulator: day plus a positive offset
  localparam int unsigned GDAC_ACC_W     = 17;
  localparam int unsigned GDAC_QUEUE_DEPTH = 2;

  localparam logic [GDAC_YEAR_W-1:0]  DEF_YEAR  = 14'd1970;
  localparam logic [GDAC_MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [GDAC_MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [GDAC_MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [GDAC_DAY_W-1:0]   DEF_DAY   = 5'd1;

  // inverse of 25 modulo 2^13 and the divisibility bound
  localparam logic [12:0] INV25   = 13'd7209;
  localparam logic [12:0] LIM25   = 13'd327;

  typedef struct packed {
    logic [GDAC_YEAR_W-1:0]   base_year;
    logic [GDAC_MONTH_W-1:0]  base_month;
    logic [GDAC_DAY_W-1:0]    base_day;
    logic signed [GDAC_OFFSET_W-1:0] day_offset;
    logic [GDAC_YEAR_W-1:0]   other_year;
    logic [GDAC_MONTH_W-1:0]  other_month;
    logic [GDAC_DAY_W-1:0]    other_day;
  } gdac_in_t;

  typedef struct packed {
    logic                     base_valid;
    logic                     other_valid;
    logic [GDAC_YEAR_W-1:0]   sum_year;
    logic [GDAC_MONTH_W-1:0]  sum_month;
    logic [GDAC_DAY_W-1:0]    sum_day;
    logic                     dates_equal;
    logic                     first_earlier;
  } gdac_out_t;

  // classified item waiting for the month walk
  typedef struct packed {
    logic                     base_valid;
    logic                     other_valid;
    logic                     dates_equal;
    logic                     first_earlier;
    logic [GDAC_YEAR_W-1:0]   year;
    logic [GDAC_MONTH_W-1:0]  month;
    logic [GDAC_ACC_W-1:0]    acc;
  } gdac_entry_t;

  // x divisible by 25, via multiply by modular inverse
  function automatic logic div25(input logic [12:0] x);
    logic [25:0] p;
    p = x * INV25;
    return p[12:0] <= LIM25;
  endfunction

  function automatic logic leap_year(input logic [GDAC_WYEAR_W-1:0] y);
    logic m100;
    logic m400;
    m100 = (y[1:0] == 2'b00) && div25(y[14:2]);
    m400 = (y[3:0] == 4'b0000) && div25({2'b00, y[14:4]});
    return ((y[1:0] == 2'b00) && !m100) || m400;
  endfunction

  // month length; codes outside 1..12 give 31 and are never used
  function automatic logic [GDAC_DAY_W-1:0] month_days(
    input logic [GDAC_WYEAR_W-1:0] y,
    input logic [GDAC_MONTH_W-1:0] m
  );
    logic [GDAC_DAY_W-1:0] len;
    case (m)
      MONTH_FEB: len = leap_year(y) ? 5'd29 : 5'd28;
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* hw/rtl/gdac_front.sv */
// ----------------------------------------------------------------------------
// gdac_front
// accepts a command beat, checks and normalizes both dates, compares them
// and prepares the day accumulator for the month walk
// ----------------------------------------------------------------------------
module gdac_front
  import gdac_pkg::*;
(
  input  logic        start_i,
  input  gdac_in_t    cmd_i,
  input  logic        full_i,
  output logic        push_o,
  output gdac_entry_t entry_o
);

  logic                    bv;
  logic                    ov;
  logic [GDAC_YEAR_W-1:0]  by;
  logic [GDAC_MONTH_W-1:0] bm;
  logic [GDAC_DAY_W-1:0]   bd;
  logic [GDAC_YEAR_W-1:0]  oy;
  logic [GDAC_MONTH_W-1:0] om;
  logic [GDAC_DAY_W-1:0]   od;

  // accept a beat whenever the queue has room
  assign push_o = start_i && !full_i;

  // date validity checks
  always_comb begin
    bv = (cmd_i.base_month inside {[4'd1:4'd12]}) && (cmd_i.base_day != '0) &&
         (cmd_i.base_year != '0) &&
         (cmd_i.base_day <= month_days({1'b0, cmd_i.base_year}, cmd_i.base_month));
    ov = (cmd_i.other_month inside {[4'd1:4'd12]}) && (cmd_i.other_day != '0) &&
         (cmd_i.other_year != '0) &&
         (cmd_i.other_day <= month_days({1'b0, cmd_i.other_year}, cmd_i.other_month));
  end

  // replace invalid dates by the default date
  always_comb begin
    by = bv ? cmd_i.base_year  : DEF_YEAR;
    bm = bv ? cmd_i.base_month : MONTH_JAN;
    bd = bv ? cmd_i.base_day   : DEF_DAY;
    oy = ov ? cmd_i.other_year  : DEF_YEAR;
    om = ov ? cmd_i.other_month : MONTH_JAN;
    od = ov ? cmd_i.other_day   : DEF_DAY;
  end

  // compare and build the queue entry
  always_comb begin
    entry_o.base_valid    = bv;
    entry_o.other_valid   = ov;
    entry_o.dates_equal   = ({by, bm, bd} == {oy, om, od});
    entry_o.first_earlier = ({by, bm, bd} <  {oy, om, od});
    entry_o.year          = by;
    entry_o.month         = bm;
    // negative offset leaves the day as is
    if (cmd_i.day_offset[GDAC_OFFSET_W-1]) begin
      entry_o.acc = GDAC_ACC_W'(bd);
    end else begin
      entry_o.acc = GDAC_ACC_W'(bd) + GDAC_ACC_W'(cmd_i.day_offset[GDAC_OFFSET_W-2:0]);
    end
  end

endmodule

/* hw/rtl/gdac_queue.sv */
// ----------------------------------------------------------------------------
// gdac_queue
// short register queue between the front and the month walker
// ----------------------------------------------------------------------------
module gdac_queue
  import gdac_pkg::*;
#(
  parameter int unsigned DEPTH = GDAC_QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  gdac_entry_t wdata_i,
  input  logic        pop_i,
  output gdac_entry_t rdata_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  gdac_entry_t        entries_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               do_push;
  logic               do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = entries_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

/* hw/rtl/gdac_walker.sv */
// ----------------------------------------------------------------------------
// gdac_walker
// adds the day accumulator to the date one month per cycle and drives
// the result beat
// ----------------------------------------------------------------------------
module gdac_walker
  import gdac_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        empty_i,
  input  gdac_entry_t entry_i,
  output logic        pop_o,
  output logic        done_o,
  output gdac_out_t   result_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                     state_q, state_d;
  logic                     done_q, done_d;
  gdac_out_t                result_q, result_d;
  logic [GDAC_WYEAR_W-1:0]  year_q, year_d;
  logic [GDAC_MONTH_W-1:0]  month_q, month_d;
  logic [GDAC_ACC_W-1:0]    acc_q, acc_d;
  logic                     bv_q, bv_d;
  logic                     ov_q, ov_d;
  logic                     eq_q, eq_d;
  logic                     lt_q, lt_d;
  logic [GDAC_DAY_W-1:0]    mdays;

  assign mdays    = month_days(year_q, month_q);
  assign done_o   = done_q;
  assign result_o = result_q;

  // load, walk one month per cycle, emit
  always_comb begin
    state_d  = state_q;
    done_d   = 1'b0;
    result_d = result_q;
    year_d   = year_q;
    month_d  = month_q;
    acc_d    = acc_q;
    bv_d     = bv_q;
    ov_d     = ov_q;
    eq_d     = eq_q;
    lt_d     = lt_q;
    pop_o    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          year_d  = GDAC_WYEAR_W'(entry_i.year);
          month_d = entry_i.month;
          acc_d   = entry_i.acc;
          bv_d    = entry_i.base_valid;
          ov_d    = entry_i.other_valid;
          eq_d    = entry_i.dates_equal;
          lt_d    = entry_i.first_earlier;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (acc_q > GDAC_ACC_W'(mdays)) begin
          acc_d = acc_q - GDAC_ACC_W'(mdays);
          // december rolls into january of the next year
          if (month_q == MONTH_DEC) begin
            month_d = MONTH_JAN;
            year_d  = year_q + 1'b1;
          end else begin
            month_d = month_q + 1'b1;
          end
        end else begin
          result_d.base_valid    = bv_q;
          result_d.other_valid   = ov_q;
          result_d.sum_year      = year_q[GDAC_YEAR_W-1:0];
          result_d.sum_month     = month_q;
          result_d.sum_day       = acc_q[GDAC_DAY_W-1:0];
          result_d.dates_equal   = eq_q;
          result_d.first_earlier = lt_q;
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  // walk and result payload
  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    year_q   <= year_d;
    month_q  <= month_d;
    acc_q    <= acc_d;
    bv_q     <= bv_d;
    ov_q     <= ov_d;
    eq_q     <= eq_d;
    lt_q     <= lt_d;
  end

endmodule

/* hw/rtl/gregorian_date_add_compare.sv */
// ----------------------------------------------------------------------------
// gregorian_date_add_compare
// validates two gregorian dates, compares them and adds a day offset
// to the first one
// ----------------------------------------------------------------------------
// channel   direction  handshake             beat
// command   in         start high, busy low  cmd_i (gdac_in_t)
// result    out        done_o for one cycle  result_o (gdac_out_t)
//
// a command beat leaves the queue into the walker, which handles one calendar
// month per cycle, registers the result beat and only then pops another beat.
// busy is high only while the command queue is full; the front keeps taking
// beats while the walker works. reset clears the queue and the walker, no
// clearing pass. the receiver cannot stall: results are never held back.
// ----------------------------------------------------------------------------
module gregorian_date_add_compare
  import gdac_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = GDAC_QUEUE_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  gdac_in_t  cmd_i,
  output logic      done_o,
  output gdac_out_t result_o
);

  gdac_entry_t push_entry;
  gdac_entry_t pop_entry;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;

  assign busy = full;

  // front: accept and classify
  gdac_front u_front (
    .start_i (start),
    .cmd_i   (cmd_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (push_entry)
  );

  // queue between front and walker
  gdac_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .pop_i   (pop),
    .rdata_o (pop_entry),
    .full_o  (full),
    .empty_o (empty)
  );

  // back: month walk
  gdac_walker u_walker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .empty_i  (empty),
    .entry_i  (pop_entry),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

/* hw/rtl/gdac_checker.sv */
// ----------------------------------------------------------------------------
// gdac_checker
// port-level checks on the result beats of the date add/compare block
// ----------------------------------------------------------------------------
`include "gregorian_date_add_compare_assert.svh"

module gdac_checker
  import gdac_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      done_o,
  input gdac_out_t result_o
);

  logic month_ok;

  assign month_ok = result_o.sum_month inside {[MONTH_JAN:MONTH_DEC]};

  // a result month is always a real month
  `GDAC_ASSERT_SAME(a_month_range, clk_i, rst_ni, done_o, month_ok)

  // a result day is never zero
  `GDAC_ASSERT_SAME(a_day_nonzero, clk_i, rst_ni, done_o, result_o.sum_day != '0)

  // equal dates cannot also be ordered
  `GDAC_ASSERT_SAME(a_eq_not_lt, clk_i, rst_ni, done_o && result_o.dates_equal, !result_o.first_earlier)

  // after each result the walker returns to idle and must load again, so results never come back to back
  `GDAC_ASSERT_NEXT(a_done_gap, clk_i, rst_ni, done_o, !done_o)

  // the queue only fills up on an accepted beat
  `GDAC_ASSERT_NEXT(a_busy_rise, clk_i, rst_ni, !busy && !start, !busy)

endmodule

bind gregorian_date_add_compare gdac_checker u_gdac_checker (.*);
